>>> src/gs_pkg.sv
// Package for the Gauss-Seidel solver: payload structs, mode codes, constants.
// Used by every module under src.
package gs_pkg;
  localparam int UNKNOWNS_DEFAULT = 3;
  localparam int MAX_UNKNOWNS = 8;

  typedef enum logic [1:0] {
    MODE_COEF  = 2'd0,
    MODE_RHS   = 2'd1,
    MODE_GUESS = 2'd2,
    MODE_SOLVE = 2'd3
  } mode_t;

  localparam logic [0:0] REG_TOLERANCE  = 1'b0;
  localparam logic [0:0] REG_MAX_SWEEPS = 1'b1;
  localparam logic [30:0] TOL_RESET = 31'd7;
  localparam logic [9:0] SWEEPS_RESET = 10'd100;

  typedef struct packed {
    logic [1:0]         mode;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         index;
    logic signed [31:0] solution;
    logic               converged;
    logic               zero_pivot;
    logic [9:0]         sweeps_done;
    logic               last;
  } out_item_t;

  // divider handshake
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

>>> src/gauss_seidel_solver.sv
// Gauss-Seidel solver in signed Q16.16. Coefficients, right side and solution
// sit in memories with registered reads. Depends on gs_pkg, gs_mem and gs_div.
//
// A load is written straight into its memory. A solve first scans the diagonal
// (states S_PIV and S_PIVW per unknown). In a sweep each unknown then takes,
// per off-diagonal term, a memory read, one 32x32 multiply and a saturating
// subtract (S_TRD, S_TMUL, S_TACC), plus row setup, a pass over the diagonal
// slot, a wait on the bit-serial divider and a write-back. Sweeps repeat until
// convergence or the sweep limit (none on a zero pivot); N beats then go out.
// The divider sets the rate. Reset: the solution store gets a clearing pass
// of UNKNOWNS cycles during which no item is accepted.
module gauss_seidel_solver
  import gs_pkg::*;
#(
  parameter int UNKNOWNS = UNKNOWNS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int AW = $clog2(UNKNOWNS * UNKNOWNS);
  localparam int XW = $clog2(UNKNOWNS);
  localparam int CW = $clog2(UNKNOWNS + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PIV, S_PIVW, S_ROW, S_TRD, S_TMUL, S_TACC,
    S_DIVW, S_DIVD, S_EMRD, S_EMIT
  } state_t;
  state_t state;

  logic [30:0] tolerance;
  logic [9:0]  max_sweeps;

  // memories
  logic          a_we, b_we, x_we;
  logic [AW-1:0] a_wa, a_ra;
  logic [XW-1:0] b_wa, b_ra, x_wa, x_ra;
  logic [31:0]   a_wd, b_wd, x_wd, a_rd, b_rd, x_rd;

  gs_mem #(.DEPTH(UNKNOWNS * UNKNOWNS)) u_a (.clk, .we(a_we), .waddr(a_wa),
    .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
  gs_mem #(.DEPTH(UNKNOWNS)) u_b (.clk, .we(b_we), .waddr(b_wa),
    .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
  gs_mem #(.DEPTH(UNKNOWNS)) u_x (.clk, .we(x_we), .waddr(x_wa),
    .wdata(x_wd), .raddr(x_ra), .rdata(x_rd));

  logic [CW-1:0] i, j;
  logic signed [31:0] sum, old_x, diag;
  logic signed [63:0] prod;
  logic [9:0] sweeps;
  logic all_close, pivot_zero, tol_met;
  logic signed [31:0] quo;
  logic div_go;
  logic div_busy, div_done;
  div_ctl_t dctl;

  // divider start comes from a register so num and den are settled
  gs_div u_div (.clk, .rst, .start(div_go), .num(sum), .den(diag),
    .busy(div_busy), .done(div_done), .quo);

  assign dctl = '{start: div_go, busy: div_busy, done: div_done};

  logic load_ok;
  assign load_ok = in_data.row < UNKNOWNS &&
    (in_data.mode != MODE_COEF || in_data.col < UNKNOWNS);
  assign in_ready = state == S_IDLE;

  logic [AW-1:0] aidx;
  assign aidx = AW'(i * UNKNOWNS + j);

  // sum - floor(prod / 2^16), saturated
  logic signed [47:0] diff;
  assign diff = 48'(sum) - 48'(prod >>> 16);
  logic signed [31:0] diff_sat;
  assign diff_sat = (diff > 48'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                    (diff < -48'sh80000000) ? 32'sh80000000 : 32'(diff);
  logic signed [32:0] delta;
  logic [32:0] mag;
  assign delta = 33'(quo) - 33'(old_x);
  assign mag = delta[32] ? 33'(-delta) : 33'(delta);

  always_comb begin
    a_we = in_valid && in_ready && in_data.mode == MODE_COEF && load_ok;
    a_wa = AW'(in_data.row * UNKNOWNS + in_data.col);
    a_wd = in_data.value;
    b_we = in_valid && in_ready && in_data.mode == MODE_RHS && load_ok;
    b_wa = XW'(in_data.row);
    b_wd = in_data.value;
    x_we = (in_valid && in_ready && in_data.mode == MODE_GUESS && load_ok)
           || state == S_CLEAR || (state == S_DIVD);
    x_wa = state == S_IDLE ? XW'(in_data.row) : XW'(i);
    x_wd = state == S_CLEAR ? 32'd0 : state == S_DIVD ? quo : in_data.value;
    a_ra = (state == S_PIV || state == S_ROW) ? AW'(i * UNKNOWNS + i) : aidx;
    b_ra = XW'(i);
    x_ra = (state == S_TRD) ? XW'(j) : XW'(i);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      i          <= '0;
      tolerance  <= TOL_RESET;
      max_sweeps <= SWEEPS_RESET;
      out_valid  <= 1'b0;
      sweeps     <= '0;
      tol_met    <= 1'b1;
      div_go     <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == 2'(REG_TOLERANCE)) tolerance <= cfg_data[30:0];
        else if (cfg_index == 2'(REG_MAX_SWEEPS)) max_sweeps <= cfg_data[9:0];
      end
      case (state)
        S_CLEAR: begin
          i <= i + CW'(1);
          if (i == CW'(UNKNOWNS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && in_data.mode == MODE_SOLVE) begin
            i <= '0;
            pivot_zero <= 1'b0;
            sweeps <= '0;
            tol_met <= 1'b0;
            state <= S_PIV;
          end
        end
        S_PIV: state <= S_PIVW;
        S_PIVW: begin
          if (a_rd == 32'd0) pivot_zero <= 1'b1;
          if (i == CW'(UNKNOWNS - 1)) begin
            i <= '0;
            all_close <= 1'b1;
            if (pivot_zero || a_rd == 32'd0 || max_sweeps == 10'd0) begin
              state <= S_EMRD;
            end else begin
              state <= S_ROW;
            end
          end else begin
            i <= i + CW'(1);
            state <= S_PIV;
          end
        end
        S_ROW: begin
          // reads of diag, b[i], x[i] were issued this cycle
          j <= '0;
          state <= S_TRD;
        end
        S_TRD: begin
          if (j == '0) begin
            diag  <= a_rd;
            sum   <= b_rd;
            old_x <= x_rd;
          end
          if (j == i) begin
            if (j == CW'(UNKNOWNS - 1)) begin
              div_go <= 1'b1;
              state <= S_DIVW;
            end else begin
              j <= j + CW'(1);
            end
          end else begin
            state <= S_TMUL;
          end
        end
        S_TMUL: begin
          prod  <= $signed(a_rd) * $signed(x_rd);
          state <= S_TACC;
        end
        S_TACC: begin
          sum <= diff_sat;
          if (j == CW'(UNKNOWNS - 1)) begin
            div_go <= 1'b1;
            state <= S_DIVW;
          end else begin
            j <= j + CW'(1);
            state <= S_TRD;
          end
        end
        S_DIVW: if (dctl.done) state <= S_DIVD;
        S_DIVD: begin
          if (mag > 33'(tolerance)) all_close <= 1'b0;
          if (i == CW'(UNKNOWNS - 1)) begin
            i <= '0;
            sweeps <= sweeps + 10'd1;
            if ((mag <= 33'(tolerance)) && all_close) begin
              tol_met <= 1'b1;
              state <= S_EMRD;
            end else if (sweeps + 10'd1 >= max_sweeps) begin
              state <= S_EMRD;
            end else begin
              all_close <= 1'b1;
              state <= S_ROW;
            end
          end else begin
            i <= i + CW'(1);
            state <= S_ROW;
          end
        end
        S_EMRD: state <= S_EMIT;
        S_EMIT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_data <= '{index: 3'(i), solution: x_rd, converged: tol_met,
                          zero_pivot: pivot_zero, sweeps_done: sweeps,
                          last: i == CW'(UNKNOWNS - 1)};
          end else if (out_ready) begin
            out_valid <= 1'b0;
            if (i == CW'(UNKNOWNS - 1)) begin
              i <= '0;
              state <= S_IDLE;
            end else begin
              i <= i + CW'(1);
              state <= S_EMRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped while stalled");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input accepted during result emission");
  assert property (@(posedge clk) disable iff (rst)
    dctl.start |=> dctl.busy)
    else $error("divider did not start");
endmodule

>>> src/gs_div.sv
// Iterative signed divider: (num * 2^16) / den, truncated toward zero,
// saturated to 32 bits. One quotient bit per cycle. Depends on gs_pkg.
module gs_div
  import gs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               busy,
  output logic               done,
  output logic signed [31:0] quo
);
  logic [47:0] dividend;
  logic [31:0] divisor;
  logic [32:0] rem;
  logic [47:0] q;
  logic [5:0]  cnt;
  logic        neg;
  logic [32:0] trial;

  assign trial = {rem[31:0], dividend[47]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= 6'd48;
        rem      <= '0;
        q        <= '0;
        neg      <= num[31] ^ den[31];
        dividend <= {(num[31] ? 32'(-num) : 32'(num)), 16'd0};
        divisor  <= den[31] ? 32'(-den) : 32'(den);
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          q   <= {q[46:0], 1'b1};
        end else begin
          rem <= {rem[31:0], dividend[47]};
          q   <= {q[46:0], 1'b0};
        end
        dividend <= {dividend[46:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (neg) begin
      quo = (q > 48'h80000000) ? 32'sh80000000 : 32'(-q);
    end else begin
      quo = (q > 48'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(q);
    end
  end
endmodule

>>> src/gs_mem.sv
// Synchronous store: one write port, one registered read port.
// Depends on gs_pkg for nothing but house style.
module gs_mem
  import gs_pkg::*;
#(
  parameter int DEPTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [31:0]              wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [31:0]              rdata
);
  logic [31:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> tb/gauss_seidel_solver_test.sv
// Self-checking testbench for gauss_seidel_solver: loads systems, runs solves
// and compares every solution beat against an in-bench Gauss-Seidel predictor.
// Depends on gs_pkg and the solver RTL under src.
`timescale 1ns / 100ps

module gauss_seidel_solver_test;
  import gs_pkg::*;

  localparam int N = UNKNOWNS_DEFAULT;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predictor state
  longint   coef_q[N*N];
  longint   rhs_q[N];
  longint   x_q[N];
  longint   tol_q = 7;
  int       sweep_cap = 100;

  out_item_t solution_fifo[$];
  bit        steady = 1'b0;
  int        mismatches = 0;
  int        solves = 0;
  int        beats_checked = 0;
  int        cycle_count = 0;

  gauss_seidel_solver u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("gauss_seidel_solver_test: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 19);
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q32.32 product floored back to Q16.16
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> 16;
  endfunction

  function automatic void run_sweeps();
    bit        pivot_zero;
    bit        all_close;
    bit        conv;
    int        done;
    longint    acc, prev, nv, diff;
    out_item_t r;
    pivot_zero = 1'b0;
    conv = 1'b0;
    done = 0;
    for (int i = 0; i < N; i++) if (coef_q[i*N+i] == 0) pivot_zero = 1'b1;
    if (!pivot_zero) begin
      while (done < sweep_cap) begin
        all_close = 1'b1;
        for (int i = 0; i < N; i++) begin
          acc = rhs_q[i];
          prev = x_q[i];
          for (int j = 0; j < N; j++)
            if (j != i) acc = sat32(acc - qmul(coef_q[i*N+j], x_q[j]));
          nv = sat32((acc * 65536) / coef_q[i*N+i]);
          x_q[i] = nv;
          diff = nv - prev;
          if (diff < 0) diff = -diff;
          if (diff > tol_q) all_close = 1'b0;
        end
        done++;
        if (all_close) begin
          conv = 1'b1;
          break;
        end
      end
    end
    for (int i = 0; i < N; i++) begin
      r.index = 3'(i);
      r.solution = x_q[i][31:0];
      r.converged = conv;
      r.zero_pivot = pivot_zero;
      r.sweeps_done = 10'(done);
      r.last = (i == N - 1);
      solution_fifo.push_back(r);
    end
    solves++;
  endfunction

  function automatic void apply_item(in_item_t it);
    longint v;
    v = longint'(it.value);
    case (mode_t'(it.mode))
      MODE_COEF:  if (it.row < N && it.col < N) coef_q[it.row*N + it.col] = v;
      MODE_RHS:   if (it.row < N) rhs_q[it.row] = v;
      MODE_GUESS: if (it.row < N) x_q[it.row] = v;
      MODE_SOLVE: run_sweeps();
      default: ;
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (solution_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %p", out_data);
      end else begin
        want = solution_fifo.pop_front();
        beats_checked++;
        if (out_data.index !== want.index || out_data.solution !== want.solution ||
            out_data.converged !== want.converged ||
            out_data.zero_pivot !== want.zero_pivot ||
            out_data.sweeps_done !== want.sweeps_done || out_data.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  function automatic in_item_t mk(mode_t m, int r, int c, logic [31:0] v);
    in_item_t it;
    it.mode = m;
    it.row = 3'(r);
    it.col = 3'(c);
    it.value = v;
    return it;
  endfunction

  // one input beat; in_valid stays high into the next call unless a gap falls
  task automatic send_item(input in_item_t it);
    if (!steady && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    apply_item(it);
  endtask

  // hold the sender until every expected beat is back, then let the block settle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (solution_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == 2'(REG_TOLERANCE)) tol_q = longint'(data[30:0]);
    else if (idx == 2'(REG_MAX_SWEEPS)) sweep_cap = int'(data[9:0]);
  endtask

  // diagonally dominant system with random content; the caller sends the solve
  task automatic load_system(input bit with_guess);
    logic [31:0] off;
    longint      row_sum;
    for (int r = 0; r < N; r++) begin
      row_sum = 0;
      for (int c = 0; c < N; c++) begin
        if (c != r) begin
          off = 32'($signed($urandom_range(524288)) - 262144);
          row_sum += ($signed(off) < 0) ? -longint'($signed(off)) : longint'($signed(off));
          send_item(mk(MODE_COEF, r, c, off));
        end
      end
      row_sum += 65536 + $urandom_range(262144);
      if ($urandom_range(1)) row_sum = -row_sum;
      send_item(mk(MODE_COEF, r, r, 32'(row_sum)));
      send_item(mk(MODE_RHS, r, $urandom_range(7), 32'($signed($urandom_range(2097152)) - 1048576)));
      if (with_guess) send_item(mk(MODE_GUESS, r, 0, 32'($signed($urandom_range(131072)) - 65536)));
    end
  endtask

  task automatic test_basic_solve();
    for (int r = 0; r < N; r++) begin
      for (int c = 0; c < N; c++)
        send_item(mk(MODE_COEF, r, c, (r == c) ? 32'h0004_0000 : 32'hFFFF_0000));
      send_item(mk(MODE_RHS, r, 0, 32'h0002_0000 + 32'(r) * 32'h0000_8000));
    end
    send_item(mk(MODE_SOLVE, 0, 0, 0));
  endtask

  task automatic test_zero_pivot();
    send_item(mk(MODE_COEF, 1, 1, 32'h0));
    send_item(mk(MODE_SOLVE, 5, 6, 32'hDEAD_BEEF));
    send_item(mk(MODE_COEF, 1, 1, 32'h0004_0000));
  endtask

  task automatic test_sweep_limits();
    write_reg(2'(REG_MAX_SWEEPS), 32'hFFFF_FC00);   // limit of zero
    send_item(mk(MODE_SOLVE, 0, 0, 0));
    write_reg(2'(REG_MAX_SWEEPS), 32'd1);
    write_reg(2'(REG_TOLERANCE), 32'h0);
    send_item(mk(MODE_GUESS, 0, 0, 32'h7FFF_FFFF));
    send_item(mk(MODE_SOLVE, 0, 0, 0));
    write_reg(2'(REG_MAX_SWEEPS), 32'd1023);
    send_item(mk(MODE_SOLVE, 7, 7, 32'hFFFF_FFFF));
    write_reg(2'(REG_TOLERANCE), 32'hFFFF_FFFF);
    send_item(mk(MODE_SOLVE, 0, 0, 0));
    write_reg(2'd2, 32'd0);                         // unmapped registers
    write_reg(2'd3, 32'hFFFF_FFFF);
    write_reg(2'(REG_TOLERANCE), 32'd7);
    write_reg(2'(REG_MAX_SWEEPS), 32'd20);
  endtask

  task automatic test_field_extremes();
    send_item(mk(MODE_COEF, 3, 0, 32'h1234_5678));  // out-of-range row, dropped
    send_item(mk(MODE_COEF, 0, 7, 32'h8000_0000));  // out-of-range col, dropped
    send_item(mk(MODE_RHS, 7, 0, 32'h8000_0000));
    send_item(mk(MODE_GUESS, 4, 0, 32'h7FFF_FFFF));
    send_item(mk(MODE_RHS, 2, 0, 32'h7FFF_FFFF));
    send_item(mk(MODE_GUESS, 1, 0, 32'h8000_0000));
    send_item(mk(MODE_COEF, 2, 0, 32'h8000_0000));  // drives the sums into saturation
    send_item(mk(MODE_SOLVE, 0, 0, 0));
  endtask

  task automatic test_random_systems();
    int          kind;
    logic [63:0] raw;
    in_item_t    junk;
    for (int seq = 0; seq < 10; seq++) begin
      if (seq % 3 == 0) begin
        write_reg(2'(REG_TOLERANCE), $urandom_range(3) == 0 ? $urandom() : $urandom_range(64));
        write_reg(2'(REG_MAX_SWEEPS), $urandom_range(12, 1));
      end
      steady = (seq == 4 || seq == 5);
      kind = $urandom_range(9);
      if (kind < 7) begin
        load_system($urandom_range(1));
        send_item(mk(MODE_SOLVE, $urandom_range(7), $urandom_range(7), $urandom()));
      end else begin
        // noise: any field values, including out-of-range indexes and huge entries
        for (int k = 0; k < 6; k++) begin
          raw = {$urandom(), $urandom()};
          junk = raw[$bits(in_item_t)-1:0];
          send_item(junk);
        end
        send_item(mk(MODE_SOLVE, 0, 0, 0));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < N; i++) begin
      rhs_q[i] = 0;
      x_q[i] = 0;
    end
    for (int i = 0; i < N*N; i++) coef_q[i] = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_basic_solve();
    test_zero_pivot();
    test_sweep_limits();
    test_field_extremes();
    test_random_systems();
    settle();
    $display("covered %0d solves, %0d solution beats checked, %0d mismatches",
             solves, beats_checked, mismatches);
    if (mismatches == 0) begin
      $display("gauss_seidel_solver_test: clean");
    end else begin
      $display("gauss_seidel_solver_test: errors");
    end
    $finish;
  end
endmodule

>>> gauss_seidel_solver.f
src/gs_pkg.sv
src/gs_div.sv
src/gs_mem.sv
src/gauss_seidel_solver.sv
tb/gauss_seidel_solver_test.sv
